@@ hw/rtl/gspc_pkg.sv @@
`timescale 1ns / 1ps

package gspc_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_MEAS  = 2'd0;
  localparam logic [1:0] KIND_CAL   = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LOW_V   = 2'd1;
  localparam logic [1:0] ST_RS_BAD  = 2'd2;
  localparam logic [1:0] ST_CAL_BAD = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_R0        = 3'd0;
  localparam logic [2:0] CFG_LOAD      = 3'd1;
  localparam logic [2:0] CFG_SUPPLY    = 3'd2;
  localparam logic [2:0] CFG_DIV_TOP   = 3'd3;
  localparam logic [2:0] CFG_DIV_BOT   = 3'd4;
  localparam logic [2:0] CFG_SLOPE     = 3'd5;
  localparam logic [2:0] CFG_OFFSET    = 3'd6;
  localparam logic [2:0] CFG_CLEAN_AIR = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Arithmetic constants.
  localparam logic [32:0] LOG10_2_Q28 = 33'd80807124;
  localparam logic [32:0] LOG2_10_Q28 = 33'd891723283;
  localparam logic [30:0] RS_MAX      = 31'h7FFF_FFFF;
  localparam logic [11:0] MV_MIN      = 12'd10;
  localparam logic [19:0] E_LIMIT     = 20'd655360;
  localparam logic [23:0] U_BIAS      = 24'd1048576;
  localparam logic [10:0] COUNT_MAX   = 11'd2047;

  // Shared divider and root unit widths.
  localparam int DIV_DVD_W = 64;
  localparam int DIV_DSR_W = 33;
  localparam int DIV_CNT_W = 6;
  localparam int SQ_IN_W   = 64;
  localparam int SQ_OUT_W  = 32;
  localparam int MUL_W     = 33;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_DVD_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [SQ_IN_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                done;
    logic [SQ_OUT_W-1:0] root;
  } sqrt_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MDEN, S_MPOS, S_MNUM, S_RSDIV, S_RSW,
    S_RATIO, S_RATIOW, S_NORM, S_SQ, S_SQW, S_L10, S_L10W,
    S_EDIV, S_EW, S_T, S_TW, S_PW, S_PWW, S_SHIFT,
    S_CAL, S_CDIV1, S_CDIV1W, S_CDIV2, S_CDIV2W, S_DONE
  } state_t;

endpackage

@@ hw/rtl/gas_sensor_ppm_converter_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Beat contents
// in_*      input      in_valid/in_stall   req_type, sense_mv, last_sample
// out_*     output     out_valid/out_stall result_kind, status, ppm, rs, r0
// cfg_*     input      cfg_wr_en           register index and write data
//
// One item is worked at a time by a sequencer around one multiplier, one
// 64-step divider and one 32-step square root unit. The measurement time is
// set mostly by the sixteen square roots of the exponent stage, plus the
// normalization shifts. A reading that is too low or gives no positive
// resistance ends before the divider is started, and a ppm that saturates or
// underflows skips the exponent stage.
// Reset is synchronous and active low; it restores the register defaults and
// clears the calibration sum and count. The next beat can be taken in the cycle
// after the result moves into the output register, which may still wait on out_stall.
module gas_sensor_ppm_converter_top #(
  parameter int MAX_CAL_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [11:0] in_sense_mv,
  input  logic        in_last_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_status,
  output logic [31:0] out_ppm_q16,
  output logic [30:0] out_rs_q8,
  output logic [30:0] out_r0_result_q8,
  input  logic        cfg_wr_en,
  input  logic [gspc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gspc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // The sample cap can never exceed what the 11-bit counter holds.
  localparam logic [10:0] CalCap = 11'((MAX_CAL_SAMPLES < gspc_pkg::COUNT_MAX) ?
                                       MAX_CAL_SAMPLES : gspc_pkg::COUNT_MAX);
  localparam int MW = gspc_pkg::MUL_W;

  gspc_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [30:0] r0_r;
  logic [19:0] load_r;
  logic [12:0] supply_r;
  logic [19:0] dtop_r;
  logic [19:0] dbot_r;
  logic [15:0] slope_r;
  logic [15:0] offset_r;
  logic [15:0] car_r;

  // Working registers of the current item.
  logic        req_r;
  logic [11:0] mv_r;
  logic        last_r;
  logic [1:0]  kind_r;
  logic [1:0]  st_r;
  logic [31:0] ppm_r;
  logic [30:0] rs_r;
  logic [30:0] r0res_r;
  logic [32:0] den_r;
  logic [46:0] nrm_r;
  logic [5:0]  p_r;
  logic [30:0] m_r;
  logic [15:0] frac_r;
  logic [3:0]  it_r;
  logic        lneg_r;
  logic [22:0] dmag_r;
  logic        eneg_r;
  logic [19:0] emag_r;
  logic [15:0] f_r;
  logic [4:0]  sh_r;
  logic [31:0] y_r;
  logic [47:0] q1_r;

  // Calibration accumulator.
  logic [47:0] sum_r;
  logic [10:0] count_r;

  // Output register.
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [1:0]  out_st_r;
  logic [31:0] out_ppm_r;
  logic [30:0] out_rs_r;
  logic [30:0] out_r0_r;

  // Shared units.
  logic [MW-1:0]   mul_a;
  logic [MW-1:0]   mul_b;
  logic [2*MW-1:0] mul_p;
  gspc_pkg::div_req_t  div_req;
  gspc_pkg::div_rsp_t  div_rsp;
  gspc_pkg::sqrt_req_t sq_req;
  gspc_pkg::sqrt_rsp_t sq_rsp;

  gspc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  gspc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  gspc_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

  logic        in_fire;
  logic        out_load;
  logic [20:0] div_sum;
  logic [32:0] pos;
  logic [32:0] num;
  logic        low_v;
  logic        rs_bad;
  logic        rs_zero;
  logic [30:0] rs_sat;
  logic [46:0] ratio;
  logic [31:0] sq;
  logic [21:0] log2v;
  logic [21:0] lmag;
  logic [22:0] l10;
  logic [22:0] off16;
  logic [22:0] diff;
  logic [15:0] slope_mag;
  logic [30:0] r0_eff;
  logic [15:0] car_eff;
  logic [34:0] eq;
  logic [21:0] tmag;
  logic [23:0] u;
  logic [32:0] yt;
  logic [63:0] wide;
  logic [48:0] sum_add;
  logic [47:0] sum_sat;
  logic        acc;
  logic [10:0] count_n;
  logic [30:0] r0_sat;

  assign in_fire  = in_valid && (state_r == gspc_pkg::S_IDLE);
  assign in_stall = (state_r != gspc_pkg::S_IDLE);
  assign out_load = (state_r == gspc_pkg::S_DONE) && (!out_valid_r || !out_stall);

  // Arithmetic around the shared units.
  always_comb begin
    div_sum   = {1'b0, dtop_r} + {1'b0, dbot_r};
    pos       = mul_p[32:0];
    num       = pos - den_r;
    low_v     = (mv_r < gspc_pkg::MV_MIN);
    rs_bad    = (pos <= den_r);
    rs_zero   = (div_rsp.quot == '0);
    rs_sat    = (|div_rsp.quot[63:31]) ? gspc_pkg::RS_MAX : div_rsp.quot[30:0];
    ratio     = (div_rsp.quot[46:0] == '0) ? 47'd1 : div_rsp.quot[46:0];
    sq        = mul_p[61:30];
    log2v     = {p_r - 6'd16, frac_r};
    lmag      = log2v[21] ? (22'd0 - log2v) : log2v;
    l10       = lneg_r ? (23'd0 - {3'd0, mul_p[47:28]}) : {3'd0, mul_p[47:28]};
    off16     = {{3{offset_r[15]}}, offset_r, 4'd0};
    diff      = l10 - off16;
    slope_mag = slope_r[15] ? (16'd0 - slope_r) : slope_r;
    r0_eff    = (r0_r == '0) ? 31'd1 : r0_r;
    car_eff   = (car_r == '0) ? 16'd1 : car_r;
    eq        = div_rsp.quot[34:0];
    tmag      = mul_p[49:28];
    u         = eneg_r ? (gspc_pkg::U_BIAS - {2'd0, tmag}) : (gspc_pkg::U_BIAS + {2'd0, tmag});
    yt        = f_r[it_r] ? {y_r, 1'b0} : {1'b0, y_r};
    wide      = {32'd0, y_r} << sh_r;
    sum_add   = {1'b0, sum_r} + {18'd0, rs_r};
    sum_sat   = sum_add[48] ? '1 : sum_add[47:0];
    acc       = (st_r == gspc_pkg::ST_OK) && (count_r < CalCap);
    count_n   = count_r + {10'd0, acc};
    r0_sat    = (|div_rsp.quot[63:31]) ? gspc_pkg::RS_MAX : div_rsp.quot[30:0];
  end

  // Operand selection for the multiplier, divider and root unit.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    sq_req.start     = 1'b0;
    sq_req.radicand  = {1'b0, yt, 30'd0};
    unique case (state_r)
      gspc_pkg::S_MDEN: begin
        mul_a = {21'd0, mv_r};
        mul_b = {12'd0, div_sum};
      end
      gspc_pkg::S_MPOS: begin
        mul_a = {20'd0, supply_r};
        mul_b = {13'd0, dbot_r};
      end
      gspc_pkg::S_MNUM: begin
        mul_a = {13'd0, load_r};
        mul_b = num;
      end
      gspc_pkg::S_SQ: begin
        mul_a = {2'd0, m_r};
        mul_b = {2'd0, m_r};
      end
      gspc_pkg::S_L10: begin
        mul_a = {11'd0, lmag};
        mul_b = gspc_pkg::LOG10_2_Q28;
      end
      gspc_pkg::S_T: begin
        mul_a = {13'd0, emag_r};
        mul_b = gspc_pkg::LOG2_10_Q28;
      end
      gspc_pkg::S_RSDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {mul_p[55:0], 8'd0};
        div_req.divisor  = den_r;
      end
      gspc_pkg::S_RATIO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {17'd0, rs_r, 16'd0};
        div_req.divisor  = {2'd0, r0_eff};
      end
      gspc_pkg::S_EDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {29'd0, dmag_r, 12'd0};
        div_req.divisor  = {17'd0, slope_mag};
      end
      gspc_pkg::S_CDIV1: begin
        div_req.start    = 1'b1;
        div_req.dividend = {16'd0, sum_r};
        div_req.divisor  = {22'd0, count_r};
      end
      gspc_pkg::S_CDIV2: begin
        div_req.start    = 1'b1;
        div_req.dividend = {4'd0, q1_r, 12'd0};
        div_req.divisor  = {17'd0, car_eff};
      end
      gspc_pkg::S_PW: begin
        sq_req.start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gspc_pkg::S_IDLE:   if (in_valid) state_nxt = gspc_pkg::S_MDEN;
      gspc_pkg::S_MDEN:   state_nxt = gspc_pkg::S_MPOS;
      gspc_pkg::S_MPOS:   state_nxt = gspc_pkg::S_MNUM;
      gspc_pkg::S_MNUM: begin
        if (low_v || rs_bad) begin
          state_nxt = req_r ? gspc_pkg::S_CAL : gspc_pkg::S_DONE;
        end else begin
          state_nxt = gspc_pkg::S_RSDIV;
        end
      end
      gspc_pkg::S_RSDIV:  state_nxt = gspc_pkg::S_RSW;
      gspc_pkg::S_RSW: begin
        if (div_rsp.done) begin
          if (req_r) state_nxt = gspc_pkg::S_CAL;
          else if (rs_zero) state_nxt = gspc_pkg::S_DONE;
          else state_nxt = gspc_pkg::S_RATIO;
        end
      end
      gspc_pkg::S_RATIO:  state_nxt = gspc_pkg::S_RATIOW;
      gspc_pkg::S_RATIOW: begin
        if (div_rsp.done) begin
          state_nxt = (slope_r == '0) ? gspc_pkg::S_DONE : gspc_pkg::S_NORM;
        end
      end
      gspc_pkg::S_NORM:   if (nrm_r[46]) state_nxt = gspc_pkg::S_SQ;
      gspc_pkg::S_SQ:     state_nxt = gspc_pkg::S_SQW;
      gspc_pkg::S_SQW:    state_nxt = (it_r == 4'd15) ? gspc_pkg::S_L10 : gspc_pkg::S_SQ;
      gspc_pkg::S_L10:    state_nxt = gspc_pkg::S_L10W;
      gspc_pkg::S_L10W:   state_nxt = gspc_pkg::S_EDIV;
      gspc_pkg::S_EDIV:   state_nxt = gspc_pkg::S_EW;
      gspc_pkg::S_EW:     if (div_rsp.done) state_nxt = gspc_pkg::S_T;
      gspc_pkg::S_T:      state_nxt = gspc_pkg::S_TW;
      gspc_pkg::S_TW: begin
        if (u[23] || (u[22:21] != 2'd0)) state_nxt = gspc_pkg::S_DONE;
        else state_nxt = gspc_pkg::S_PW;
      end
      gspc_pkg::S_PW:     state_nxt = gspc_pkg::S_PWW;
      gspc_pkg::S_PWW: begin
        if (sq_rsp.done) begin
          state_nxt = (it_r == 4'd15) ? gspc_pkg::S_SHIFT : gspc_pkg::S_PW;
        end
      end
      gspc_pkg::S_SHIFT:  state_nxt = gspc_pkg::S_DONE;
      gspc_pkg::S_CAL: begin
        if (!last_r || (count_n == '0)) state_nxt = gspc_pkg::S_DONE;
        else state_nxt = gspc_pkg::S_CDIV1;
      end
      gspc_pkg::S_CDIV1:  state_nxt = gspc_pkg::S_CDIV1W;
      gspc_pkg::S_CDIV1W: if (div_rsp.done) state_nxt = gspc_pkg::S_CDIV2;
      gspc_pkg::S_CDIV2:  state_nxt = gspc_pkg::S_CDIV2W;
      gspc_pkg::S_CDIV2W: if (div_rsp.done) state_nxt = gspc_pkg::S_DONE;
      gspc_pkg::S_DONE:   if (out_load) state_nxt = gspc_pkg::S_IDLE;
      default:            state_nxt = gspc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gspc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes are expected only while the sequencer is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0_r     <= 31'd426642;
      load_r   <= 20'd19530;
      supply_r <= 13'd5000;
      dtop_r   <= 20'd10000;
      dbot_r   <= 20'd20000;
      slope_r  <= 16'hFA66;
      offset_r <= 16'd3277;
      car_r    <= 16'd14746;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gspc_pkg::CFG_R0:        r0_r     <= cfg_wdata[30:0];
        gspc_pkg::CFG_LOAD:      load_r   <= cfg_wdata[19:0];
        gspc_pkg::CFG_SUPPLY:    supply_r <= cfg_wdata[12:0];
        gspc_pkg::CFG_DIV_TOP:   dtop_r   <= cfg_wdata[19:0];
        gspc_pkg::CFG_DIV_BOT:   dbot_r   <= cfg_wdata[19:0];
        gspc_pkg::CFG_SLOPE:     slope_r  <= cfg_wdata[15:0];
        gspc_pkg::CFG_OFFSET:    offset_r <= cfg_wdata[15:0];
        gspc_pkg::CFG_CLEAN_AIR: car_r    <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // The calibration sum and count persist across items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else if (state_r == gspc_pkg::S_CAL) begin
      if (last_r && (count_n == '0)) begin
        sum_r   <= '0;
        count_r <= '0;
      end else if (acc) begin
        sum_r   <= sum_sat;
        count_r <= count_n;
      end
    end else if ((state_r == gspc_pkg::S_CDIV2W) && div_rsp.done) begin
      sum_r   <= '0;
      count_r <= '0;
    end
  end

  // Per-item datapath.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_req_type;
      mv_r    <= in_sense_mv;
      last_r  <= in_last_sample;
      kind_r  <= in_req_type ? gspc_pkg::KIND_CAL : gspc_pkg::KIND_MEAS;
      st_r    <= gspc_pkg::ST_OK;
      ppm_r   <= '0;
      rs_r    <= '0;
      r0res_r <= '0;
    end else begin
      unique case (state_r)
        gspc_pkg::S_MPOS: den_r <= mul_p[32:0];
        gspc_pkg::S_MNUM: begin
          if (low_v) st_r <= gspc_pkg::ST_LOW_V;
          else if (rs_bad) st_r <= gspc_pkg::ST_RS_BAD;
        end
        gspc_pkg::S_RSW: begin
          if (div_rsp.done) begin
            if (rs_zero) st_r <= gspc_pkg::ST_RS_BAD;
            else rs_r <= rs_sat;
          end
        end
        gspc_pkg::S_RATIOW: begin
          if (div_rsp.done) begin
            ppm_r <= '1;
            nrm_r <= ratio;
            p_r   <= 6'd46;
          end
        end
        gspc_pkg::S_NORM: begin
          if (nrm_r[46]) begin
            m_r    <= nrm_r[46:16];
            frac_r <= '0;
            it_r   <= '0;
          end else begin
            nrm_r <= {nrm_r[45:0], 1'b0};
            p_r   <= p_r - 1'b1;
          end
        end
        gspc_pkg::S_SQW: begin
          // One squaring step yields one fraction bit of the logarithm.
          m_r    <= sq[31] ? sq[31:1] : sq[30:0];
          frac_r <= {frac_r[14:0], sq[31]};
          it_r   <= it_r + 1'b1;
        end
        gspc_pkg::S_L10: lneg_r <= log2v[21];
        gspc_pkg::S_L10W: begin
          dmag_r <= diff[22] ? (23'd0 - diff) : diff;
          eneg_r <= diff[22] ^ slope_r[15];
        end
        gspc_pkg::S_EW: begin
          if (div_rsp.done) begin
            emag_r <= (eq > {15'd0, gspc_pkg::E_LIMIT}) ? gspc_pkg::E_LIMIT : eq[19:0];
          end
        end
        gspc_pkg::S_TW: begin
          if (u[23]) ppm_r <= '0;
          f_r  <= u[15:0];
          sh_r <= u[20:16];
          y_r  <= 32'd1 << 30;
          it_r <= '0;
        end
        gspc_pkg::S_PWW: begin
          if (sq_rsp.done) begin
            y_r  <= sq_rsp.root;
            it_r <= it_r + 1'b1;
          end
        end
        gspc_pkg::S_SHIFT: ppm_r <= wide[61:30];
        gspc_pkg::S_CAL: begin
          if (last_r) begin
            kind_r <= gspc_pkg::KIND_FINAL;
            st_r   <= (count_n == '0) ? gspc_pkg::ST_CAL_BAD : gspc_pkg::ST_OK;
          end
        end
        gspc_pkg::S_CDIV1W: if (div_rsp.done) q1_r <= div_rsp.quot[47:0];
        gspc_pkg::S_CDIV2W: if (div_rsp.done) r0res_r <= r0_sat;
        default: begin
        end
      endcase
    end
  end

  // Output register: holds a finished beat while the sequencer moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= kind_r;
      out_st_r   <= st_r;
      out_ppm_r  <= ppm_r;
      out_rs_r   <= rs_r;
      out_r0_r   <= r0res_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_status       = out_st_r;
  assign out_ppm_q16      = out_ppm_r;
  assign out_rs_q8        = out_rs_r;
  assign out_r0_result_q8 = out_r0_r;

endmodule

@@ hw/rtl/gspc_mul.sv @@
`timescale 1ns / 1ps

// Shared unsigned multiplier with a registered product.
module gspc_mul (
  input  logic                            clk,
  input  logic [gspc_pkg::MUL_W-1:0]      a,
  input  logic [gspc_pkg::MUL_W-1:0]      b,
  output logic [2*gspc_pkg::MUL_W-1:0]    p
);

  logic [2*gspc_pkg::MUL_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

@@ hw/rtl/gspc_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module gspc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gspc_pkg::div_req_t  req,
  output gspc_pkg::div_rsp_t  rsp
);

  localparam int DW = gspc_pkg::DIV_DVD_W;
  localparam int SW = gspc_pkg::DIV_DSR_W;
  localparam int CW = gspc_pkg::DIV_CNT_W;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] div_r;
  logic [DW-1:0] quo_r;
  logic [SW:0]   shifted;
  logic [SW+1:0] trial;
  logic          qbit;
  logic [SW-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    trial   = {1'b0, shifted} - {2'b00, div_r};
    qbit    = !trial[SW+1];
    rem_nxt = qbit ? trial[SW-1:0] : shifted[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DW-2:0], qbit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

@@ hw/rtl/gspc_sqrt.sv @@
`timescale 1ns / 1ps

// Digit-by-digit integer square root, two radicand bits per cycle.
module gspc_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gspc_pkg::sqrt_req_t  req,
  output gspc_pkg::sqrt_rsp_t  rsp
);

  localparam int IW = gspc_pkg::SQ_IN_W;

  logic          busy_r;
  logic          done_r;
  logic [IW-1:0] v_r;
  logic [IW-1:0] r_r;
  logic [IW-1:0] b_r;
  logic [IW-1:0] sum;
  logic          ge;

  always_comb begin
    sum = r_r + b_r;
    ge  = (v_r >= sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && b_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      v_r <= req.radicand;
      r_r <= '0;
      b_r <= IW'(1) << (IW - 2);
    end else if (busy_r) begin
      v_r <= ge ? (v_r - sum) : v_r;
      r_r <= ge ? ((r_r >> 1) + b_r) : (r_r >> 1);
      b_r <= b_r >> 2;
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = r_r[gspc_pkg::SQ_OUT_W-1:0];

endmodule

@@ hw/rtl/gspc_checker.sv @@
`timescale 1ns / 1ps

module gspc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_result_kind,
  input logic [1:0]  out_status,
  input logic [31:0] out_ppm_q16,
  input logic [30:0] out_r0_result_q8
);

  // An accepted beat keeps the sequencer busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item still in work");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ppm_q16) && $stable(out_status))
    else $error("stalled result changed");

  // Concentration is only reported for a good measurement.
  a_ppm_meaning: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != gspc_pkg::KIND_MEAS || out_status != gspc_pkg::ST_OK)
    |-> out_ppm_q16 == '0)
    else $error("ppm on a non-measurement or failed beat");

  // Calibrated r0 is only reported on a good final calibration beat.
  a_r0_meaning: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != gspc_pkg::KIND_FINAL || out_status != gspc_pkg::ST_OK)
    |-> out_r0_result_q8 == '0)
    else $error("r0 on a beat that is not a good final");

endmodule

bind gas_sensor_ppm_converter_top gspc_checker u_gspc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_result_kind(out_result_kind),
  .out_status(out_status),
  .out_ppm_q16(out_ppm_q16),
  .out_r0_result_q8(out_r0_result_q8)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int CAL_CAP = 1024;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] ppm;
    logic [30:0] rs;
    logic [30:0] r0;
  } conv_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic [11:0] in_sense_mv = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [1:0] out_status;
  logic [31:0] out_ppm_q16;
  logic [30:0] out_rs_q8;
  logic [30:0] out_r0_result_q8;
  logic cfg_wr_en = 1'b0;
  logic [gspc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gspc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  gas_sensor_ppm_converter_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req_type(in_req_type),
    .in_sense_mv(in_sense_mv), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_status(out_status),
    .out_ppm_q16(out_ppm_q16), .out_rs_q8(out_rs_q8),
    .out_r0_result_q8(out_r0_result_q8),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mirror of the block's registers and calibration accumulator.
  longint unsigned reg_r0, reg_load, reg_supply, reg_top, reg_bot;
  logic [15:0] reg_slope, reg_offset, reg_clean_air;
  longint unsigned cal_sum, cal_count;

  conv_result_t pending_results[$];
  int error_count = 0;
  int in_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Base-2 log of a Q16 ratio, Q16 result, fraction bits by repeated squaring.
  function automatic longint log2_fixed(longint unsigned r);
    int p;
    longint unsigned m;
    longint frac;
    p = 63;
    frac = 0;
    while (p > 0 && r[p] == 1'b0) p--;
    m = (p >= 30) ? (r >> (p - 30)) : (r << (30 - p));
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return longint'(p - 16) * 65536 + frac;
  endfunction

  // 2^(f/65536) in Q30 by sixteen square roots.
  function automatic longint unsigned exp2_frac(longint unsigned f);
    longint unsigned y;
    y = 64'd1 << 30;
    for (int j = 0; j < 16; j++) begin
      if (f[j]) y <<= 1;
      y = int_sqrt(y << 30);
    end
    return y;
  endfunction

  function automatic logic [1:0] sensor_resistance(longint unsigned mv,
                                                    output longint unsigned rs);
    longint unsigned den, pos, q;
    rs = 0;
    if (mv < 10) return gspc_pkg::ST_LOW_V;
    den = mv * (reg_top + reg_bot);
    pos = reg_supply * reg_bot;
    if (pos <= den) return gspc_pkg::ST_RS_BAD;
    q = (reg_load * (pos - den) * 256) / den;
    if (q == 0) return gspc_pkg::ST_RS_BAD;
    rs = (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
    return gspc_pkg::ST_OK;
  endfunction

  function automatic logic [31:0] gas_ppm(longint unsigned rs);
    longint unsigned r0, ratio, y;
    longint slope, offset, l10, diff, e, t, u;
    r0 = (reg_r0 != 0) ? reg_r0 : 1;
    ratio = (rs << 16) / r0;
    slope = longint'($signed(reg_slope));
    offset = longint'($signed(reg_offset));
    if (ratio == 0) ratio = 1;
    if (slope == 0) return 32'hFFFF_FFFF;
    l10 = (log2_fixed(ratio) * 80807124) / (longint'(1) << 28);
    diff = l10 - offset * 16;
    e = (diff * 4096) / slope;
    if (e > 10 * 65536) e = 10 * 65536;
    if (e < -10 * 65536) e = -10 * 65536;
    t = (e * 891723283) / (longint'(1) << 28);
    u = t + 16 * 65536;
    if (u >= 32 * 65536) return 32'hFFFF_FFFF;
    if (u < 0) return 32'd0;
    y = exp2_frac(longint'(u) & 16'hFFFF);
    return 32'((y << (u >> 16)) >> 30);
  endfunction

  // Works out the result of one accepted beat and updates the accumulator.
  function automatic conv_result_t predict_conversion(logic req, logic [11:0] mv,
                                                      logic last);
    conv_result_t res;
    longint unsigned rs, car, q;
    logic [1:0] st;
    st = sensor_resistance(mv, rs);
    res.ppm = '0;
    res.r0 = '0;
    if (req == 1'b0) begin
      res.kind = gspc_pkg::KIND_MEAS;
      if (st == gspc_pkg::ST_OK) res.ppm = gas_ppm(rs);
    end else begin
      if (st == gspc_pkg::ST_OK && cal_count < CAL_CAP) begin
        cal_sum = (64'hFFFF_FFFF_FFFF - cal_sum < rs) ? 64'hFFFF_FFFF_FFFF
                                                      : cal_sum + rs;
        cal_count++;
      end
      res.kind = gspc_pkg::KIND_CAL;
      if (last) begin
        res.kind = gspc_pkg::KIND_FINAL;
        if (cal_count == 0) begin
          st = gspc_pkg::ST_CAL_BAD;
        end else begin
          car = (reg_clean_air != 0) ? reg_clean_air : 1;
          q = ((cal_sum / cal_count) * 4096) / car;
          res.r0 = (q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : q[30:0];
          st = gspc_pkg::ST_OK;
        end
        cal_sum = 0;
        cal_count = 0;
      end
    end
    res.status = st;
    res.rs = rs[30:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Registers are only written with the input side quiet and nothing pending.
  task automatic write_reg(logic [gspc_pkg::CFG_IDX_W-1:0] idx, longint unsigned value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value[gspc_pkg::CFG_DATA_W-1:0];
    case (idx)
      gspc_pkg::CFG_R0:        reg_r0 = value & 64'h7FFF_FFFF;
      gspc_pkg::CFG_LOAD:      reg_load = value & 64'hF_FFFF;
      gspc_pkg::CFG_SUPPLY:    reg_supply = value & 64'h1FFF;
      gspc_pkg::CFG_DIV_TOP:   reg_top = value & 64'hF_FFFF;
      gspc_pkg::CFG_DIV_BOT:   reg_bot = value & 64'hF_FFFF;
      gspc_pkg::CFG_SLOPE:     reg_slope = value[15:0];
      gspc_pkg::CFG_OFFSET:    reg_offset = value[15:0];
      gspc_pkg::CFG_CLEAN_AIR: reg_clean_air = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic restore_defaults();
    write_reg(gspc_pkg::CFG_R0, 426642);
    write_reg(gspc_pkg::CFG_LOAD, 19530);
    write_reg(gspc_pkg::CFG_SUPPLY, 5000);
    write_reg(gspc_pkg::CFG_DIV_TOP, 10000);
    write_reg(gspc_pkg::CFG_DIV_BOT, 20000);
    write_reg(gspc_pkg::CFG_SLOPE, 16'hFA66);
    write_reg(gspc_pkg::CFG_OFFSET, 3277);
    write_reg(gspc_pkg::CFG_CLEAN_AIR, 14746);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Sends one beat; valid stays high afterwards so beats can go back to back.
  task automatic send_beat(logic req, logic [11:0] mv, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = req;
    in_sense_mv = mv;
    in_last_sample = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_conversion(req, mv, last));
    @(negedge clk);
  endtask

  // Mostly voltages that give a positive resistance, sometimes any voltage.
  function automatic logic [11:0] pick_voltage();
    longint unsigned lim;
    lim = (reg_top + reg_bot != 0) ? reg_supply * reg_bot / (reg_top + reg_bot) : 0;
    if (lim > 4095) lim = 4095;
    if (lim > 11 && $urandom_range(9) < 7) return 12'($urandom_range(10, lim - 1));
    return 12'($urandom_range(4095));
  endfunction

  task automatic random_config();
    write_reg(gspc_pkg::CFG_R0, $urandom_range(256, 40000000));
    write_reg(gspc_pkg::CFG_LOAD, $urandom_range(100, 200000));
    write_reg(gspc_pkg::CFG_SUPPLY, $urandom_range(1000, 8191));
    write_reg(gspc_pkg::CFG_DIV_TOP, $urandom_range(0, 50000));
    write_reg(gspc_pkg::CFG_DIV_BOT, $urandom_range(1, 50000));
    write_reg(gspc_pkg::CFG_SLOPE, $urandom_range(9) == 0 ? $urandom_range(16'hFFFF)
                                   : 16'hFFFF - $urandom_range(100, 4000));
    write_reg(gspc_pkg::CFG_OFFSET, $urandom_range(16'hFFFF));
    write_reg(gspc_pkg::CFG_CLEAN_AIR, $urandom_range(1, 65535));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, both operations, low voltage, bad resistance, empty final.
  task automatic test_directed();
    send_beat(1'b0, 12'd0, 1'b0);
    send_beat(1'b0, 12'd9, 1'b1);
    send_beat(1'b0, 12'd10, 1'b0);
    send_beat(1'b0, 12'd4095, 1'b0);
    send_beat(1'b0, 12'd1500, 1'b0);
    send_beat(1'b0, 12'd3333, 1'b1);
    // A final with no valid sample reports a failed calibration.
    send_beat(1'b1, 12'd5, 1'b0);
    send_beat(1'b1, 12'd4095, 1'b1);
    send_beat(1'b1, 12'd1200, 1'b0);
    send_beat(1'b1, 12'd2000, 1'b0);
    send_beat(1'b1, 12'd0, 1'b0);
    send_beat(1'b1, 12'd2700, 1'b1);
    send_beat(1'b1, 12'd10, 1'b1);
    drain();
  endtask

  // Registers at their limits, including the zero values taken as one.
  task automatic test_register_extremes();
    write_reg(gspc_pkg::CFG_R0, 0);
    write_reg(gspc_pkg::CFG_SLOPE, 0);
    send_beat(1'b0, 12'd1000, 1'b0);
    drain();
    write_reg(gspc_pkg::CFG_SLOPE, 16'h8000);
    write_reg(gspc_pkg::CFG_OFFSET, 16'h7FFF);
    send_beat(1'b0, 12'd1000, 1'b0);
    drain();
    write_reg(gspc_pkg::CFG_R0, 31'h7FFF_FFFF);
    write_reg(gspc_pkg::CFG_SLOPE, 16'h7FFF);
    write_reg(gspc_pkg::CFG_OFFSET, 16'h8000);
    write_reg(gspc_pkg::CFG_LOAD, 20'hF_FFFF);
    write_reg(gspc_pkg::CFG_SUPPLY, 13'h1FFF);
    write_reg(gspc_pkg::CFG_DIV_TOP, 0);
    write_reg(gspc_pkg::CFG_CLEAN_AIR, 0);
    send_beat(1'b0, 12'd10, 1'b0);
    send_beat(1'b1, 12'd10, 1'b0);
    send_beat(1'b1, 12'd11, 1'b1);
    drain();
    write_reg(gspc_pkg::CFG_DIV_BOT, 0);
    send_beat(1'b0, 12'd100, 1'b0);
    drain();
    write_reg(gspc_pkg::CFG_DIV_TOP, 20'hF_FFFF);
    write_reg(gspc_pkg::CFG_DIV_BOT, 20'hF_FFFF);
    write_reg(gspc_pkg::CFG_LOAD, 1);
    write_reg(gspc_pkg::CFG_SUPPLY, 1);
    write_reg(gspc_pkg::CFG_CLEAN_AIR, 16'hFFFF);
    send_beat(1'b0, 12'd10, 1'b0);
    drain();
    restore_defaults();
  endtask

  // More valid samples than the accumulator takes, then a final.
  task automatic test_accumulator_cap();
    for (int i = 0; i < CAL_CAP + 6; i++)
      send_beat(1'b1, 12'($urandom_range(500, 3300)), 1'b0);
    send_beat(1'b1, 12'd2000, 1'b1);
    drain();
  endtask

  task automatic test_random_traffic(int idle, int stall, int beats);
    in_idle_pct = idle;
    stall_pct = stall;
    random_config();
    for (int i = 0; i < beats; i++) begin
      if ($urandom_range(1)) send_beat(1'b0, pick_voltage(), 1'($urandom_range(1)));
      else send_beat(1'b1, pick_voltage(), $urandom_range(7) == 0);
      // Once per phase the sender holds off until the block has drained.
      if (i == beats / 2) drain();
    end
    drain();
    in_idle_pct = 0;
    stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------
  // Checker, output stall generator and watchdog
  // ---------------------------------------------------------------------

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    conv_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, kind %0d", $time, out_result_kind);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_result_kind !== exp_res.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_res.kind,
                   out_result_kind);
          error_count++;
        end
        if (out_status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                   out_status);
          error_count++;
        end
        if (out_ppm_q16 !== exp_res.ppm) begin
          $display("%0t: ppm expected %0d actual %0d", $time, exp_res.ppm, out_ppm_q16);
          error_count++;
        end
        if (out_rs_q8 !== exp_res.rs) begin
          $display("%0t: rs expected %0d actual %0d", $time, exp_res.rs, out_rs_q8);
          error_count++;
        end
        if (out_r0_result_q8 !== exp_res.r0) begin
          $display("%0t: r0 expected %0d actual %0d", $time, exp_res.r0,
                   out_r0_result_q8);
          error_count++;
        end
      end
    end
  end

  // Counts cycles in which no beat moves on either channel or the config port.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reg_r0 = 426642;
    reg_load = 19530;
    reg_supply = 5000;
    reg_top = 10000;
    reg_bot = 20000;
    reg_slope = 16'hFA66;
    reg_offset = 16'd3277;
    reg_clean_air = 16'd14746;
    cal_sum = 0;
    cal_count = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_register_extremes();
    test_accumulator_cap();
    test_random_traffic(0, 0, 130);
    test_random_traffic(66, 0, 130);
    test_random_traffic(0, 66, 130);
    test_random_traffic(37, 37, 130);

    repeat (100) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
